// ----- rtl/tlik_pkg.sv -----
package tlik_pkg;

  // Number formats
  localparam int COORD_FRAC_BITS   = 16;
  localparam int ANGLE_FRAC_BITS   = 13;
  localparam int CORDIC_ITERATIONS = 16;

  localparam int POS_W     = 20;
  localparam int LEN_W     = 19;
  localparam int ANG_OUT_W = 16;
  localparam int DP_W      = 56;   // CORDIC x/y datapath
  localparam int ANG_W     = 35;   // internal Q.30 angles, room for +-2pi
  localparam int CNT_W     = $clog2(CORDIC_ITERATIONS);
  localparam int RND_SHIFT = 30 - ANGLE_FRAC_BITS;

  typedef logic signed [DP_W-1:0]  dp_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  // Link length reset: 0.4 m
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'((2 << COORD_FRAC_BITS) / 5);

  // Q.30 angle constants
  localparam ang_t IA_PI      = ANG_W'(64'sd3373259426);
  localparam ang_t IA_HALF_PI = ANG_W'(64'sd1686629713);
  localparam ang_t IA_SAT     = ANG_W'(64'sd2717347871);
  localparam logic [29:0] IA_KINV = 30'd652032874;

  // Register indexes
  localparam logic REG_LOWER_LEN = 1'b0;
  localparam logic REG_UPPER_LEN = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
  } in_t;

  typedef struct packed {
    logic signed [ANG_OUT_W-1:0] lower_angle;
    logic signed [ANG_OUT_W-1:0] upper_angle;
    logic                        out_of_reach;
  } out_t;

  // CORDIC engine command and result
  typedef struct packed {
    logic vec;     // 1: vectoring (atan2), 0: rotation
    dp_t  x;
    dp_t  y;
    ang_t z;
  } cor_cmd_t;

  typedef struct packed {
    dp_t  x;
    dp_t  y;
    ang_t z;
  } cor_res_t;

  // atan(2^-i) in Q.30, rounded
  function automatic logic [30:0] atan_q30(input logic [4:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      5'd24: v = 31'd64;
      5'd25: v = 31'd32;
      5'd26: v = 31'd16;
      5'd27: v = 31'd8;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      5'd30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/tlik_cordic.sv -----
module tlik_cordic import tlik_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  cor_cmd_t cmd,
  output logic     done,
  output cor_res_t res
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_PREP = 4'b0010,
    C_ITER = 4'b0100,
    C_DONE = 4'b1000
  } cst_t;

  localparam dp_t NORM_LIM = DP_W'(64'd1 << 40);
  localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(CORDIC_ITERATIONS - 1);

  cst_t             cst;
  logic             vec;
  dp_t              x;
  dp_t              y;
  ang_t             z;
  logic [CNT_W-1:0] i;

  dp_t  dx;
  dp_t  dy;
  ang_t at;
  logic below_lim;
  logic plus;

  // Shared micro-rotation terms
  always_comb begin
    dx        = y >>> i;
    dy        = x >>> i;
    at        = {{(ANG_W-31){1'b0}}, atan_q30(5'(i))};
    below_lim = (x > -NORM_LIM) && (x < NORM_LIM) && (y > -NORM_LIM) && (y < NORM_LIM);
    plus      = vec ? (y > 0) : (z >= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst <= C_IDLE;
    end else begin
      case (cst)
        C_IDLE: begin
          if (start) begin
            vec <= cmd.vec;
            x   <= cmd.x;
            y   <= cmd.y;
            z   <= cmd.z;
            cst <= C_PREP;
          end
        end
        // normalise and fold into the right half plane
        C_PREP: begin
          i <= '0;
          if (vec) begin
            if (x == 0 && y == 0) begin
              z   <= '0;
              cst <= C_DONE;
            end else if (below_lim) begin
              x <= x <<< 1;
              y <= y <<< 1;
            end else begin
              if (x < 0) begin
                z <= (y >= 0) ? IA_PI : -IA_PI;
                x <= -x;
                y <= -y;
              end
              cst <= C_ITER;
            end
          end else begin
            if (z > IA_HALF_PI) begin
              y <= x;
              x <= '0;
              z <= z - IA_HALF_PI;
            end else if (z < -IA_HALF_PI) begin
              y <= -x;
              x <= '0;
              z <= z + IA_HALF_PI;
            end
            cst <= C_ITER;
          end
        end
        C_ITER: begin
          if (vec) begin
            if (plus) begin
              x <= x + dx; y <= y - dy; z <= z + at;
            end else begin
              x <= x - dx; y <= y + dy; z <= z - at;
            end
          end else begin
            if (plus) begin
              x <= x - dx; y <= y + dy; z <= z - at;
            end else begin
              x <= x + dx; y <= y - dy; z <= z + at;
            end
          end
          if (i == LAST_ITER) begin
            cst <= C_DONE;
          end else begin
            i <= i + 1'b1;
          end
        end
        C_DONE: begin
          cst <= C_IDLE;
        end
        default: cst <= C_IDLE;
      endcase
    end
  end

  assign done  = (cst == C_DONE);
  assign res.x = x;
  assign res.y = y;
  assign res.z = z;

endmodule

// ----- rtl/two_link_inverse_kinematics_top.sv -----
// Two-link arm inverse kinematics, one transaction in flight at a time.
// A rejected target goes straight to the output; otherwise the work is set by the
// shared CORDIC engine (four passes of 16 micro-rotations, the three vectoring passes
// with up to 40 normalising shifts each) and the bit-serial root and divider.
// A new target is taken only once the previous result has been accepted.
// Reset (synchronous): link lengths 0.4 m, held angles zero, no result pending.
module two_link_inverse_kinematics_top import tlik_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_data
);

  typedef enum logic [32:0] {
    S_IDLE   = 33'b1 << 0,
    S_MXX    = 33'b1 << 1,
    S_MYY    = 33'b1 << 2,
    S_MSUM   = 33'b1 << 3,
    S_MDIF   = 33'b1 << 4,
    S_ML1    = 33'b1 << 5,
    S_ML2    = 33'b1 << 6,
    S_ADD    = 33'b1 << 7,
    S_TEST   = 33'b1 << 8,
    S_SQ     = 33'b1 << 9,
    S_SQR    = 33'b1 << 10,
    S_MDEN   = 33'b1 << 11,
    S_DINIT  = 33'b1 << 12,
    S_DCHK   = 33'b1 << 13,
    S_DIV    = 33'b1 << 14,
    S_DCLAMP = 33'b1 << 15,
    S_MMAG   = 33'b1 << 16,
    S_SQ2I   = 33'b1 << 17,
    S_CT     = 33'b1 << 18,
    S_WT     = 33'b1 << 19,
    S_CP     = 33'b1 << 20,
    S_WP     = 33'b1 << 21,
    S_LOW    = 33'b1 << 22,
    S_MKI    = 33'b1 << 23,
    S_CR     = 33'b1 << 24,
    S_WR     = 33'b1 << 25,
    S_CU     = 33'b1 << 26,
    S_WU     = 33'b1 << 27,
    S_UP     = 33'b1 << 28,
    S_WRAP   = 33'b1 << 29,
    S_SAT    = 33'b1 << 30,
    S_RND    = 33'b1 << 31,
    S_OUT    = 33'b1 << 32
  } state_t;

  localparam logic [41:0] SQ_TOP   = 42'(64'd1 << 40);
  localparam logic [20:0] COS_ONE  = 21'(1 << 20);
  localparam ang_t        RND_HALF = ANG_W'(64'sd1 <<< (RND_SHIFT - 1));

  state_t state;

  // configuration and held angles
  logic [LEN_W-1:0]            l1;
  logic [LEN_W-1:0]            l2;
  logic signed [ANG_OUT_W-1:0] held_lower;
  logic signed [ANG_OUT_W-1:0] held_upper;

  // per-transaction working registers
  logic signed [POS_W-1:0] xr;
  logic signed [POS_W-1:0] yr;
  logic [19:0]             ax;
  logic [19:0]             ay;
  logic [19:0]             lsum;
  logic [18:0]             ldif;
  logic [39:0]             xx;
  logic [39:0]             yy;
  logic [39:0]             sumsq;
  logic [37:0]             difsq;
  logic [37:0]             l1sq;
  logic [37:0]             l2sq;
  logic [39:0]             d2;
  logic [41:0]             nn;
  logic [41:0]             sq_d;
  logic [41:0]             sq_r;
  logic [41:0]             sq_bit;
  logic                    sq_second;
  logic [20:0]             root;
  logic [40:0]             den;
  logic [61:0]             rem;
  logic [61:0]             dsh;
  logic [20:0]             q;
  logic [4:0]              dk;
  logic [20:0]             mag;
  logic [41:0]             msq;
  logic [48:0]             kx;
  ang_t                    t;
  ang_t                    pos;
  ang_t                    lower;
  ang_t                    ua;
  ang_t                    upd;
  dp_t                     rx;
  dp_t                     ry;

  // shared multiplier
  logic [20:0] mul_a;
  logic [29:0] mul_b;
  logic [50:0] mul_p;

  // root step, divider step, CORDIC port
  logic [41:0] sq_sum;
  logic        sq_ge;
  logic        div_ge;
  logic [41:0] nabs;
  dp_t         cm;
  logic        cor_start;
  cor_cmd_t    cor_cmd;
  logic        cor_done;
  cor_res_t    cor_res;

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MXX:   begin mul_a = {1'b0, ax};   mul_b = {10'b0, ax};   end
      S_MYY:   begin mul_a = {1'b0, ay};   mul_b = {10'b0, ay};   end
      S_MSUM:  begin mul_a = {1'b0, lsum}; mul_b = {10'b0, lsum}; end
      S_MDIF:  begin mul_a = {2'b0, ldif}; mul_b = {11'b0, ldif}; end
      S_ML1:   begin mul_a = {2'b0, l1};   mul_b = {11'b0, l1};   end
      S_ML2:   begin mul_a = {2'b0, l2};   mul_b = {11'b0, l2};   end
      S_MDEN:  begin mul_a = {2'b0, l1};   mul_b = {9'b0, root};  end
      S_MMAG:  begin mul_a = mag;          mul_b = {9'b0, mag};   end
      S_MKI:   begin mul_a = {2'b0, l1};   mul_b = IA_KINV;       end
      default: begin mul_a = '0;           mul_b = '0;            end
    endcase
  end
  assign mul_p = 51'(mul_a) * 51'(mul_b);

  // Root and divider steps
  assign sq_sum = sq_r + sq_bit;
  assign sq_ge  = (sq_d >= sq_sum);
  assign div_ge = (rem >= dsh);
  assign nabs   = nn[41] ? -nn : nn;
  assign cm     = {{(DP_W-21){1'b0}}, mag};

  // CORDIC command selection
  always_comb begin
    cor_start   = 1'b0;
    cor_cmd.vec = 1'b1;
    cor_cmd.x   = '0;
    cor_cmd.y   = '0;
    cor_cmd.z   = '0;
    case (state)
      S_CT: begin
        cor_start = 1'b1;
        cor_cmd.x = nn[41] ? -cm : cm;
        cor_cmd.y = {{(DP_W-21){1'b0}}, root};
      end
      S_CP: begin
        cor_start = 1'b1;
        cor_cmd.x = {{(DP_W-POS_W){xr[POS_W-1]}}, xr};
        cor_cmd.y = {{(DP_W-POS_W){yr[POS_W-1]}}, yr};
      end
      S_CR: begin
        cor_start   = 1'b1;
        cor_cmd.vec = 1'b0;
        cor_cmd.x   = {{(DP_W-49){1'b0}}, kx};
        cor_cmd.z   = lower;
      end
      S_CU: begin
        cor_start = 1'b1;
        cor_cmd.x = ({{(DP_W-POS_W){xr[POS_W-1]}}, xr} <<< 30) - rx;
        cor_cmd.y = ({{(DP_W-POS_W){yr[POS_W-1]}}, yr} <<< 30) - ry;
      end
      default: cor_start = 1'b0;
    endcase
  end

  tlik_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .cmd   (cor_cmd),
    .done  (cor_done),
    .res   (cor_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= LEN_RESET;
      l2 <= LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOWER_LEN: l1 <= cfg_data;
        REG_UPPER_LEN: l2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_lower <= '0;
      held_upper <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            xr    <= in_data.target_x;
            yr    <= in_data.target_y;
            ax    <= in_data.target_x[POS_W-1] ? 20'(-in_data.target_x)
                                               : in_data.target_x;
            ay    <= in_data.target_y[POS_W-1] ? 20'(-in_data.target_y)
                                               : in_data.target_y;
            lsum  <= {1'b0, l1} + {1'b0, l2};
            ldif  <= (l1 >= l2) ? (l1 - l2) : (l2 - l1);
            state <= S_MXX;
          end
        end
        S_MXX:  begin xx    <= mul_p[39:0]; state <= S_MYY;  end
        S_MYY:  begin yy    <= mul_p[39:0]; state <= S_MSUM; end
        S_MSUM: begin sumsq <= mul_p[39:0]; state <= S_MDIF; end
        S_MDIF: begin difsq <= mul_p[37:0]; state <= S_ML1;  end
        S_ML1:  begin l1sq  <= mul_p[37:0]; state <= S_ML2;  end
        S_ML2:  begin l2sq  <= mul_p[37:0]; state <= S_ADD;  end
        S_ADD:  begin d2    <= xx + yy;     state <= S_TEST; end
        // reach test; a rejected target repeats the held angles
        S_TEST: begin
          if (d2 > sumsq || d2 < {2'b0, difsq} || d2 == 0 || l1 == 0) begin
            out_data.lower_angle  <= held_lower;
            out_data.upper_angle  <= held_upper;
            out_data.out_of_reach <= 1'b1;
            state                 <= S_OUT;
          end else begin
            nn        <= {4'b0, l1sq} + {2'b0, d2} - {4'b0, l2sq};
            sq_d      <= {2'b0, d2};
            sq_r      <= '0;
            sq_bit    <= SQ_TOP;
            sq_second <= 1'b0;
            state     <= S_SQ;
          end
        end
        // bit-pair square root
        S_SQ: begin
          if (sq_ge) begin
            sq_d <= sq_d - sq_sum;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            state <= S_SQR;
          end
        end
        S_SQR: begin
          root  <= 21'(sq_r + {41'b0, (sq_d > sq_r)});
          state <= sq_second ? S_CT : S_MDEN;
        end
        S_MDEN: begin
          den   <= {mul_p[39:0], 1'b0};
          state <= S_DINIT;
        end
        // cosine magnitude: rounded |n| * 2^20 / den
        S_DINIT: begin
          rem   <= {1'b0, nabs[40:0], 20'b0} + {22'b0, den[40:1]};
          dsh   <= {den, 21'b0};
          state <= S_DCHK;
        end
        S_DCHK: begin
          if (div_ge) begin
            mag   <= COS_ONE;
            state <= S_MMAG;
          end else begin
            dsh   <= dsh >> 1;
            q     <= '0;
            dk    <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_ge) begin
            rem <= rem - dsh;
          end
          q   <= {q[19:0], div_ge};
          dsh <= dsh >> 1;
          dk  <= dk + 1'b1;
          if (dk == 5'd20) begin
            state <= S_DCLAMP;
          end
        end
        S_DCLAMP: begin
          mag   <= (q > COS_ONE) ? COS_ONE : q;
          state <= S_MMAG;
        end
        S_MMAG: begin
          msq   <= mul_p[41:0];
          state <= S_SQ2I;
        end
        // sine = root of (1 - c^2)
        S_SQ2I: begin
          sq_d      <= SQ_TOP - msq;
          sq_r      <= '0;
          sq_bit    <= SQ_TOP;
          sq_second <= 1'b1;
          state     <= S_SQ;
        end
        S_CT: state <= S_WT;
        S_WT: begin
          if (cor_done) begin
            t     <= cor_res.z;
            state <= S_CP;
          end
        end
        S_CP: state <= S_WP;
        S_WP: begin
          if (cor_done) begin
            pos   <= cor_res.z;
            state <= S_LOW;
          end
        end
        S_LOW: begin
          lower <= pos - t;
          state <= S_MKI;
        end
        // link length prescaled by the inverse CORDIC gain; lower wrapped
        S_MKI: begin
          kx    <= mul_p[48:0];
          lower <= (lower < -IA_PI) ? (lower + (IA_PI <<< 1)) : lower;
          state <= S_CR;
        end
        S_CR: state <= S_WR;
        S_WR: begin
          if (cor_done) begin
            rx    <= cor_res.x;
            ry    <= cor_res.y;
            state <= S_CU;
          end
        end
        S_CU: state <= S_WU;
        S_WU: begin
          if (cor_done) begin
            ua    <= cor_res.z;
            state <= S_UP;
          end
        end
        S_UP: begin
          upd   <= ua - lower;
          state <= S_WRAP;
        end
        S_WRAP: begin
          if (upd > IA_PI) begin
            upd <= upd - (IA_PI <<< 1);
          end else if (upd <= -IA_PI) begin
            upd <= upd + (IA_PI <<< 1);
          end
          state <= S_SAT;
        end
        S_SAT: begin
          if (upd > IA_SAT) begin
            upd <= IA_SAT;
          end else if (upd < -IA_SAT) begin
            upd <= -IA_SAT;
          end
          state <= S_RND;
        end
        // round Q.30 to output format and remember
        S_RND: begin
          held_lower            <= ANG_OUT_W'((lower + RND_HALF) >>> RND_SHIFT);
          held_upper            <= ANG_OUT_W'((upd + RND_HALF) >>> RND_SHIFT);
          out_data.lower_angle  <= ANG_OUT_W'((lower + RND_HALF) >>> RND_SHIFT);
          out_data.upper_angle  <= ANG_OUT_W'((upd + RND_HALF) >>> RND_SHIFT);
          out_data.out_of_reach <= 1'b0;
          state                 <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

// ----- tb/tb_top.sv -----
module tb_top import tlik_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_PI      = 64'sd3373259426;
  localparam longint Q_HALF_PI = 64'sd1686629713;
  localparam longint Q_SAT     = 64'sd2717347871;
  localparam longint Q_KINV    = 64'sd652032874;
  localparam int     COS_Q     = 20;
  localparam longint CYCLE_LIMIT = 64'd2000000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_LOWER_LEN;
  logic [LEN_W-1:0] cfg_data = '0;

  two_link_inverse_kinematics_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [LEN_W-1:0]     lower_len, upper_len;
  logic [ANG_OUT_W-1:0] last_lower, last_upper;

  in_t    target_q[$];
  out_t   angles_q[$];
  int     fail_count = 0;
  longint cycle_count = 0;
  bit     driver_hold = 1'b0;
  int     drive_gap = 0;
  int     sink_gap = 0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Integer square root, rounded to nearest
  function automatic longint root_round(longint unsigned d);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > d) b >>= 2;
    while (b != 0) begin
      if (d >= r + b) begin
        d -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (d > r) r++;
    return longint'(r);
  endfunction

  function automatic longint atan_entry(int i);
    return (i < 32) ? longint'(atan_q30(5'(i))) : 64'sd0;
  endfunction

  // Vectoring CORDIC: atan2(y, x) in Q.30
  function automatic longint vec_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while (absl(x) < (64'sd1 << 40) && absl(y) < (64'sd1 << 40)) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      z = (y >= 0) ? Q_PI : -Q_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y > 0) begin
        t = x + dx; y = y - dy; x = t; z += atan_entry(i);
      end else begin
        t = x - dx; y = y + dy; x = t; z -= atan_entry(i);
      end
    end
    return z;
  endfunction

  // Rotation CORDIC of the gain-corrected link
  task automatic rotate_link(input longint len, input longint phi,
                             output longint ox, output longint oy);
    longint x, y, t, dx, dy;
    x = len * Q_KINV;
    y = 0;
    if (phi > Q_HALF_PI) begin
      y = x; x = 0; phi -= Q_HALF_PI;
    end else if (phi < -Q_HALF_PI) begin
      y = -x; x = 0; phi += Q_HALF_PI;
    end
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (phi >= 0) begin
        t = x - dx; y = y + dy; x = t; phi -= atan_entry(i);
      end else begin
        t = x + dx; y = y - dy; x = t; phi += atan_entry(i);
      end
    end
    ox = x;
    oy = y;
  endtask

  function automatic logic [ANG_OUT_W-1:0] narrow_angle(longint z);
    return ANG_OUT_W'(shr(z + (64'sd1 << (RND_SHIFT - 1)), RND_SHIFT));
  endfunction

  // Joint angles for one target, updating the held angles when it is in reach
  task automatic solve_joints(input in_t tgt, output out_t res);
    longint x, y, l1, l2, sum, dif, l3, n, c, t, pos, lower, upper, rx, ry;
    longint unsigned d2, den, mag, s;
    x = longint'(tgt.target_x);
    y = longint'(tgt.target_y);
    l1 = longint'(lower_len);
    l2 = longint'(upper_len);
    d2 = x * x + y * y;
    sum = l1 + l2;
    dif = absl(l1 - l2);
    if (d2 > sum * sum || d2 < dif * dif || d2 == 0 || l1 == 0) begin
      res.lower_angle  = last_lower;
      res.upper_angle  = last_upper;
      res.out_of_reach = 1'b1;
      return;
    end
    l3 = root_round(d2);
    den = 2 * l1 * l3;
    n = l1 * l1 + longint'(d2) - l2 * l2;
    mag = longint'(absl(n)) << COS_Q;
    mag = (mag + den / 2) / den;
    if (mag > (64'd1 << COS_Q)) mag = 64'd1 << COS_Q;
    c = n < 0 ? -longint'(mag) : longint'(mag);
    s = root_round((64'd1 << (2 * COS_Q)) - mag * mag);
    t = vec_angle(longint'(s), c);
    pos = vec_angle(y, x);
    lower = pos - t;
    if (lower < -Q_PI) lower += 2 * Q_PI;
    rotate_link(l1, lower, rx, ry);
    upper = vec_angle(y * (64'sd1 << 30) - ry, x * (64'sd1 << 30) - rx) - lower;
    if (upper > Q_PI) upper -= 2 * Q_PI;
    else if (upper <= -Q_PI) upper += 2 * Q_PI;
    if (upper > Q_SAT) upper = Q_SAT;
    else if (upper < -Q_SAT) upper = -Q_SAT;
    last_lower = narrow_angle(lower);
    last_upper = narrow_angle(upper);
    res.lower_angle  = last_lower;
    res.upper_angle  = last_upper;
    res.out_of_reach = 1'b0;
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  // Driver: presents queued targets with random gaps
  always @(posedge clk) begin
    out_t exp_res;
    if (!rst) begin
      if (in_valid && in_ready) begin
        solve_joints(in_data, exp_res);
        angles_q.push_back(exp_res);
        void'(target_q.pop_front());
        drive_gap = idle_len();
      end
      if (in_valid && !in_ready) begin
        // hold the transaction
      end else if (drive_gap > 0) begin
        drive_gap--;
        in_valid <= 1'b0;
      end else if (!driver_hold && target_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= target_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks results and stalls the output at random
  always @(posedge clk) begin
    out_t exp_res;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (angles_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_res = angles_q.pop_front();
          if (out_data.lower_angle !== exp_res.lower_angle)
            report_mismatch($sformatf("lower_angle %0d expected %0d",
              out_data.lower_angle, exp_res.lower_angle));
          if (out_data.upper_angle !== exp_res.upper_angle)
            report_mismatch($sformatf("upper_angle %0d expected %0d",
              out_data.upper_angle, exp_res.upper_angle));
          if (out_data.out_of_reach !== exp_res.out_of_reach)
            report_mismatch($sformatf("out_of_reach %0b expected %0b",
              out_data.out_of_reach, exp_res.out_of_reach));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        sink_gap = idle_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Random target: mostly within the workspace ring, sometimes anywhere
  function automatic in_t pick_target();
    in_t tg;
    longint r, rad, lo, hi;
    int ang;
    real a;
    if ($urandom_range(0, 3) == 0) begin
      tg.target_x = POS_W'($urandom);
      tg.target_y = POS_W'($urandom);
      return tg;
    end
    lo = absl(longint'(lower_len) - longint'(upper_len));
    hi = longint'(lower_len) + longint'(upper_len);
    if (hi > 500000) hi = 500000;
    if (lo > hi) lo = hi;
    rad = lo + longint'($urandom_range(0, 1000000)) * (hi - lo) / 1000000;
    ang = $urandom_range(0, 35999);
    a = ang * 3.14159265358979 / 18000.0;
    r = longint'($rtoi(rad * $cos(a)));
    tg.target_x = POS_W'(r);
    r = longint'($rtoi(rad * $sin(a)));
    tg.target_y = POS_W'(r);
    return tg;
  endfunction

  task automatic queue_target(input longint x, input longint y);
    in_t tg;
    tg.target_x = POS_W'(x);
    tg.target_y = POS_W'(y);
    target_q.push_back(tg);
  endtask

  task automatic wait_idle();
    while (target_q.size() > 0 || in_valid || angles_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Register write while the block is idle
  task automatic write_len(input logic idx, input logic [LEN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LOWER_LEN) lower_len = val;
    else upper_len = val;
    @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) queue_target(0, 0);
    for (int i = 0; i < count; i++) target_q[target_q.size() - count + i] = pick_target();
    wait_idle();
  endtask

  initial begin
    lower_len  = LEN_RESET;
    upper_len  = LEN_RESET;
    last_lower = '0;
    last_upper = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: origin, extremes, reach edges, axes, dead zone
    queue_target(0, 0);
    queue_target(-524288, -524288);
    queue_target(524287, 524287);
    queue_target(524287, 0);
    queue_target(-524288, 0);
    queue_target(0, -524288);
    queue_target(52428, 0);
    queue_target(52429, 0);
    queue_target(0, 52428);
    queue_target(-52428, 0);
    queue_target(0, -30000);
    queue_target(20000, 20000);
    queue_target(-20000, 15000);
    queue_target(-26214, -1);
    queue_target(-26214, 1);
    queue_target(1, 0);
    wait_idle();

    // Unequal links: inner dead zone, then exact-fold targets
    write_len(REG_LOWER_LEN, 19'd40000);
    write_len(REG_UPPER_LEN, 19'd10000);
    queue_target(29999, 0);
    queue_target(30000, 0);
    queue_target(0, 50000);
    queue_target(-50001, 0);
    queue_target(35000, -5000);
    queue_target(0, 0);
    wait_idle();
    random_phase(250);

    // Zero lower link, then zero upper link
    write_len(REG_LOWER_LEN, 19'd0);
    queue_target(10000, 0);
    queue_target(-1000, 5000);
    wait_idle();
    write_len(REG_LOWER_LEN, 19'd30000);
    write_len(REG_UPPER_LEN, 19'd0);
    queue_target(30000, 0);
    queue_target(0, -30000);
    queue_target(21213, 21213);
    wait_idle();
    random_phase(100);

    // Largest lengths
    write_len(REG_LOWER_LEN, 19'h7FFFF);
    write_len(REG_UPPER_LEN, 19'h7FFFF);
    queue_target(524287, 524287);
    queue_target(-524288, 0);
    wait_idle();
    random_phase(200);

    // Short lower link, upper longer than lower
    write_len(REG_LOWER_LEN, 19'd1000);
    write_len(REG_UPPER_LEN, 19'd70000);
    random_phase(200);

    // Back to reset lengths, then a run with the sender paused midway
    write_len(REG_LOWER_LEN, LEN_RESET);
    write_len(REG_UPPER_LEN, LEN_RESET);
    random_phase(150);
    for (int i = 0; i < 150; i++) target_q.push_back(pick_target());
    while (target_q.size() > 75) @(posedge clk);
    // sender paused until every outstanding result is back
    driver_hold = 1'b1;
    while (in_valid || angles_q.size() > 0) @(posedge clk);
    driver_hold = 1'b0;
    wait_idle();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
